// File: design/tvp_pkg.sv
// shared types and constants for the trapezoid velocity-from-position unit
// no dependencies; used by tvp_div_pipe, tvp_sqrt_pipe and the top level
package tvp_pkg;

  // region codes of a result word
  localparam logic [2:0] REGION_INVALID = 3'd0;
  localparam logic [2:0] REGION_HOLD    = 3'd1;
  localparam logic [2:0] REGION_BEFORE  = 3'd2;
  localparam logic [2:0] REGION_PAST    = 3'd3;
  localparam logic [2:0] REGION_ACCEL   = 3'd4;
  localparam logic [2:0] REGION_CRUISE  = 3'd5;
  localparam logic [2:0] REGION_DECEL   = 3'd6;

  // configuration register indexes
  localparam int CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] REG_START_POSITION = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_END_POSITION   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_START_SPEED    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PEAK_SPEED     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_FINAL_SPEED    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_ACCEL_FRACTION = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_DECEL_FRACTION = 3'd6;

  // path fractions: 17 bits, 65536 means the whole path
  localparam int FRAC_W     = 17;
  localparam int FRAC_SHIFT = 16;
  localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h10000;

  // control that travels with each word down the pipeline
  typedef struct packed {
    logic [2:0] region;
    logic       neg;       // negate the final magnitude
    logic       use_root;  // magnitude comes from the square root
    logic       sub;       // subtract the quotient from the base square
  } ctrl_t;

endpackage

// File: design/tvp_div_pipe.sv
// pipelined restoring divider, one quotient bit per stage
// depends on tvp_pkg (ctrl_t); quotient must fit in QUOT_W bits
module tvp_div_pipe #(
  parameter int QUOT_W = 40,
  parameter int DEN_W  = 24,
  parameter int SIDE_W = 60
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     valid_in,
  input  tvp_pkg::ctrl_t           ctrl_in,
  input  logic [SIDE_W-1:0]        side_in,
  input  logic [QUOT_W+DEN_W-1:0]  dividend,
  input  logic [DEN_W-1:0]         divisor,
  output logic                     valid_out,
  output tvp_pkg::ctrl_t           ctrl_out,
  output logic [SIDE_W-1:0]        side_out,
  output logic [QUOT_W-1:0]        quotient
);

  logic                valid [0:QUOT_W];
  tvp_pkg::ctrl_t      ctrl  [0:QUOT_W];
  logic [SIDE_W-1:0]   side  [0:QUOT_W];
  logic [DEN_W-1:0]    rem   [0:QUOT_W];
  logic [QUOT_W-1:0]   work  [0:QUOT_W];  // dividend bits out at top, quotient bits in at bottom
  logic [DEN_W-1:0]    den   [0:QUOT_W];

  // stage zero: top part of the dividend is already below the divisor
  assign valid[0] = valid_in;
  assign ctrl[0]  = ctrl_in;
  assign side[0]  = side_in;
  assign rem[0]   = dividend[QUOT_W +: DEN_W];
  assign work[0]  = dividend[QUOT_W-1:0];
  assign den[0]   = divisor;

  for (genvar k = 0; k < QUOT_W; k++) begin : g_stage
    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           ge;

    // shift in the next dividend bit and try a subtract
    assign trial = {rem[k], work[k][QUOT_W-1]};
    assign diff  = trial - {1'b0, den[k]};
    assign ge    = trial >= {1'b0, den[k]};

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[k+1] <= 1'b0;
      end else begin
        valid[k+1] <= valid[k];
      end
    end

    always_ff @(posedge clk) begin
      ctrl[k+1] <= ctrl[k];
      side[k+1] <= side[k];
      den[k+1]  <= den[k];
      rem[k+1]  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      work[k+1] <= {work[k][QUOT_W-2:0], ge};
    end
  end

  assign valid_out = valid[QUOT_W];
  assign ctrl_out  = ctrl[QUOT_W];
  assign side_out  = side[QUOT_W];
  assign quotient  = work[QUOT_W];

endmodule

// File: design/tvp_sqrt_pipe.sv
// pipelined integer square root, one root bit per stage
// depends on tvp_pkg (ctrl_t)
module tvp_sqrt_pipe #(
  parameter int ROOT_W = 20,
  parameter int SIDE_W = 20
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  valid_in,
  input  tvp_pkg::ctrl_t        ctrl_in,
  input  logic [SIDE_W-1:0]     side_in,
  input  logic [2*ROOT_W-1:0]   radicand,
  output logic                  valid_out,
  output tvp_pkg::ctrl_t        ctrl_out,
  output logic [SIDE_W-1:0]     side_out,
  output logic [ROOT_W-1:0]     root
);

  logic                  valid [0:ROOT_W];
  tvp_pkg::ctrl_t        ctrl  [0:ROOT_W];
  logic [SIDE_W-1:0]     side  [0:ROOT_W];
  logic [ROOT_W+1:0]     rem   [0:ROOT_W];
  logic [2*ROOT_W-1:0]   rad   [0:ROOT_W];
  logic [ROOT_W-1:0]     res   [0:ROOT_W];

  assign valid[0] = valid_in;
  assign ctrl[0]  = ctrl_in;
  assign side[0]  = side_in;
  assign rem[0]   = '0;
  assign rad[0]   = radicand;
  assign res[0]   = '0;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic [ROOT_W+3:0] trial;
    logic [ROOT_W+3:0] sub;
    logic [ROOT_W+3:0] diff;
    logic              ge;

    // bring down two radicand bits, try 4*root+1
    assign trial = {rem[k], rad[k][2*ROOT_W-1 -: 2]};
    assign sub   = {2'b00, res[k], 2'b01};
    assign diff  = trial - sub;
    assign ge    = trial >= sub;

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[k+1] <= 1'b0;
      end else begin
        valid[k+1] <= valid[k];
      end
    end

    always_ff @(posedge clk) begin
      ctrl[k+1] <= ctrl[k];
      side[k+1] <= side[k];
      rem[k+1]  <= ge ? diff[ROOT_W+1:0] : trial[ROOT_W+1:0];
      rad[k+1]  <= {rad[k][2*ROOT_W-3:0], 2'b00};
      res[k+1]  <= {res[k][ROOT_W-2:0], ge};
    end
  end

  assign valid_out = valid[ROOT_W];
  assign ctrl_out  = ctrl[ROOT_W];
  assign side_out  = side[ROOT_W];
  assign root      = res[ROOT_W];

endmodule

// File: design/trapezoid_velocity_from_position_unit.sv
// top level: trapezoidal speed profile planned from a position sample
// depends on tvp_pkg, tvp_div_pipe, tvp_sqrt_pipe
//
//  channel   signals                              dir   when taken
//  command   start, position (busy out)           in    start && !busy
//  result    done, target_speed, region           out   every cycle done is high
//  config    cfg_we, cfg_index, cfg_data          in    cfg_we high
//
// one word enters per cycle; each result passes the classify, ramp, scaling and product stages,
// the one-bit-per-stage divider, the squared-speed stage, the root and the output register
// busy follows rst, so no word is taken while reset is asserted
// reset clears the valid bits and the settings registers to zero
// nothing stalls: the result side has no hold-off and the pipeline always moves
module trapezoid_velocity_from_position_unit #(
  parameter int POSITION_WIDTH = 24,
  parameter int SPEED_WIDTH    = 20,
  parameter int FRACTION_BITS  = 8,
  localparam int CfgWidth =
    (POSITION_WIDTH > SPEED_WIDTH)
      ? ((POSITION_WIDTH > tvp_pkg::FRAC_W) ? POSITION_WIDTH : tvp_pkg::FRAC_W)
      : ((SPEED_WIDTH > tvp_pkg::FRAC_W) ? SPEED_WIDTH : tvp_pkg::FRAC_W)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [POSITION_WIDTH-1:0]  position,
  output logic                              done,
  output logic signed [SPEED_WIDTH:0]       target_speed,
  output logic [2:0]                        region,
  input  logic                              cfg_we,
  input  logic [tvp_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [CfgWidth-1:0]               cfg_data
);

  localparam int P  = POSITION_WIDTH;
  localparam int S  = SPEED_WIDTH;
  localparam int S2 = 2 * SPEED_WIDTH;
  localparam int FW = tvp_pkg::FRAC_W;

  // configuration registers
  logic signed [P-1:0] start_position;
  logic signed [P-1:0] end_position;
  logic [S-1:0]        start_speed;
  logic [S-1:0]        peak_speed;
  logic [S-1:0]        final_speed;
  logic [FW-1:0]       accel_fraction;
  logic [FW-1:0]       decel_fraction;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_position <= '0;
      end_position   <= '0;
      start_speed    <= '0;
      peak_speed     <= '0;
      final_speed    <= '0;
      accel_fraction <= '0;
      decel_fraction <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        tvp_pkg::REG_START_POSITION: start_position <= cfg_data[P-1:0];
        tvp_pkg::REG_END_POSITION:   end_position   <= cfg_data[P-1:0];
        tvp_pkg::REG_START_SPEED:    start_speed    <= cfg_data[S-1:0];
        tvp_pkg::REG_PEAK_SPEED:     peak_speed     <= cfg_data[S-1:0];
        tvp_pkg::REG_FINAL_SPEED:    final_speed    <= cfg_data[S-1:0];
        tvp_pkg::REG_ACCEL_FRACTION: accel_fraction <= cfg_data[FW-1:0];
        tvp_pkg::REG_DECEL_FRACTION: decel_fraction <= cfg_data[FW-1:0];
        default: ;
      endcase
    end
  end

  assign busy = rst;

  logic accept;
  assign accept = start && !busy;

  // stage 1: classify the sample, path length and distance from start
  logic signed [P:0] ps_x, pe_x, pos_x, path_diff, s_diff;
  logic              bad_cfg, hold_mode, up, before_start, past_end;
  logic [P-1:0]      path_c, s_c;

  assign ps_x      = {start_position[P-1], start_position};
  assign pe_x      = {end_position[P-1], end_position};
  assign pos_x     = {position[P-1], position};
  assign path_diff = pe_x - ps_x;
  assign s_diff    = pos_x - ps_x;
  assign bad_cfg   = (accel_fraction > tvp_pkg::FRAC_ONE)
                  || (decel_fraction > tvp_pkg::FRAC_ONE)
                  || (peak_speed < start_speed);
  assign hold_mode = (start_position == end_position);
  assign up        = end_position > start_position;
  assign before_start = up ? (position < start_position) : (position > start_position);
  assign past_end     = up ? (position > end_position) : (position < end_position);

  always_comb begin
    logic [P:0] neg_path, neg_s;
    neg_path = -path_diff;
    neg_s    = -s_diff;
    path_c   = path_diff[P] ? neg_path[P-1:0] : path_diff[P-1:0];
    s_c      = s_diff[P] ? neg_s[P-1:0] : s_diff[P-1:0];
  end

  logic           v1;
  tvp_pkg::ctrl_t ctrl1;
  logic           inside1;
  logic [P-1:0]   path1, s1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= accept;
    end
  end

  always_ff @(posedge clk) begin
    path1          <= path_c;
    s1             <= s_c;
    ctrl1.use_root <= 1'b0;
    ctrl1.sub      <= 1'b0;
    ctrl1.neg      <= !bad_cfg && !hold_mode && !up;
    inside1        <= 1'b0;
    if (bad_cfg) begin
      ctrl1.region <= tvp_pkg::REGION_INVALID;
    end else if (hold_mode) begin
      ctrl1.region <= tvp_pkg::REGION_HOLD;
    end else if (before_start) begin
      ctrl1.region <= tvp_pkg::REGION_BEFORE;
    end else if (past_end) begin
      ctrl1.region <= tvp_pkg::REGION_PAST;
    end else begin
      ctrl1.region <= tvp_pkg::REGION_CRUISE;
      inside1      <= 1'b1;
    end
  end

  // stage 2: ramp lengths, squared speeds and hold product
  logic [P+FW-1:0] sac_prod, sde_prod;
  logic [S2-1:0]   hold_prod, hold_shift;
  assign sac_prod   = {{FW{1'b0}}, path1} * {{P{1'b0}}, accel_fraction};
  assign sde_prod   = {{FW{1'b0}}, path1} * {{P{1'b0}}, decel_fraction};
  assign hold_prod  = {{S{1'b0}}, start_speed} * {{S{1'b0}}, peak_speed};
  assign hold_shift = hold_prod >> FRACTION_BITS;

  logic           v2;
  tvp_pkg::ctrl_t ctrl2;
  logic           inside2;
  logic [P-1:0]   path2, s2, sac2, sde2;
  logic [S2-1:0]  vs_sq2, vp_sq2, vf_sq2;
  logic [S-1:0]   hold_mag2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    ctrl2     <= ctrl1;
    inside2   <= inside1;
    path2     <= path1;
    s2        <= s1;
    sac2      <= sac_prod[tvp_pkg::FRAC_SHIFT +: P];
    sde2      <= sde_prod[tvp_pkg::FRAC_SHIFT +: P];
    vs_sq2    <= {{S{1'b0}}, start_speed} * {{S{1'b0}}, start_speed};
    vp_sq2    <= {{S{1'b0}}, peak_speed} * {{S{1'b0}}, peak_speed};
    vf_sq2    <= {{S{1'b0}}, final_speed} * {{S{1'b0}}, final_speed};
    hold_mag2 <= (|hold_shift[S2-1:S]) ? {S{1'b1}} : hold_shift[S-1:0];
  end

  // stage 3: pick the ramp or a direct speed and set up the scaling
  logic [P-1:0] cruise_end, rest_dist;
  logic         in_accel, in_cruise;
  assign cruise_end = path2 - sde2;
  assign rest_dist  = path2 - s2;
  assign in_accel   = s2 < sac2;
  assign in_cruise  = s2 < cruise_end;

  logic           v3;
  tvp_pkg::ctrl_t ctrl3;
  logic [S2-1:0]  delta3, base3;
  logic [P-1:0]   num3, den3;
  logic [S-1:0]   dmag3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    ctrl3  <= ctrl2;
    delta3 <= '0;
    base3  <= vf_sq2;
    num3   <= rest_dist;
    den3   <= {{(P-1){1'b0}}, 1'b1};
    case (ctrl2.region)
      tvp_pkg::REGION_HOLD:   dmag3 <= hold_mag2;
      tvp_pkg::REGION_BEFORE: dmag3 <= start_speed;
      tvp_pkg::REGION_PAST:   dmag3 <= final_speed;
      tvp_pkg::REGION_CRUISE: dmag3 <= peak_speed;
      default:                dmag3 <= '0;
    endcase
    if (inside2) begin
      if (in_accel) begin
        ctrl3.region   <= tvp_pkg::REGION_ACCEL;
        ctrl3.use_root <= 1'b1;
        delta3         <= vp_sq2 - vs_sq2;
        base3          <= vs_sq2;
        num3           <= s2;
        den3           <= sac2;
      end else if (!in_cruise) begin
        ctrl3.region   <= tvp_pkg::REGION_DECEL;
        ctrl3.use_root <= 1'b1;
        // a zero decel length leaves only the final speed
        if (sde2 != '0) begin
          den3 <= sde2;
          if (vp_sq2 >= vf_sq2) begin
            delta3 <= vp_sq2 - vf_sq2;
          end else begin
            delta3    <= vf_sq2 - vp_sq2;
            ctrl3.sub <= 1'b1;
          end
        end
      end
    end
  end

  // stage 4: partial products of delta times distance
  logic           v4;
  tvp_pkg::ctrl_t ctrl4;
  logic [S+P-1:0] pp_lo4, pp_hi4;
  logic [S2-1:0]  base4;
  logic [P-1:0]   den4;
  logic [S-1:0]   dmag4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    ctrl4  <= ctrl3;
    pp_lo4 <= {{P{1'b0}}, delta3[S-1:0]} * {{S{1'b0}}, num3};
    pp_hi4 <= {{P{1'b0}}, delta3[S2-1:S]} * {{S{1'b0}}, num3};
    base4  <= base3;
    den4   <= den3;
    dmag4  <= dmag3;
  end

  // stage 5: full product
  logic            v5;
  tvp_pkg::ctrl_t  ctrl5;
  logic [S2+P-1:0] prod5;
  logic [S2-1:0]   base5;
  logic [P-1:0]    den5;
  logic [S-1:0]    dmag5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    ctrl5 <= ctrl4;
    prod5 <= {pp_hi4, {S{1'b0}}} + {{S{1'b0}}, pp_lo4};
    base5 <= base4;
    den5  <= den4;
    dmag5 <= dmag4;
  end

  // divider: quotient of product over ramp length
  logic           vd;
  tvp_pkg::ctrl_t ctrld;
  logic [S2+S-1:0] sided;
  logic [S2-1:0]  quot;

  tvp_div_pipe #(
    .QUOT_W (S2),
    .DEN_W  (P),
    .SIDE_W (S2 + S)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .valid_in  (v5),
    .ctrl_in   (ctrl5),
    .side_in   ({base5, dmag5}),
    .dividend  (prod5),
    .divisor   (den5),
    .valid_out (vd),
    .ctrl_out  (ctrld),
    .side_out  (sided),
    .quotient  (quot)
  );

  // stage 6: squared speed
  logic [S2-1:0]  base_d;
  assign base_d = sided[S +: S2];

  logic           v6;
  tvp_pkg::ctrl_t ctrl6;
  logic [S2-1:0]  sq6;
  logic [S-1:0]   dmag6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else begin
      v6 <= vd;
    end
  end

  always_ff @(posedge clk) begin
    ctrl6 <= ctrld;
    sq6   <= ctrld.sub ? (base_d - quot) : (base_d + quot);
    dmag6 <= sided[S-1:0];
  end

  // square root of the squared speed
  logic           vr;
  tvp_pkg::ctrl_t ctrlr;
  logic [S-1:0]   dmagr;
  logic [S-1:0]   root;

  tvp_sqrt_pipe #(
    .ROOT_W (S),
    .SIDE_W (S)
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .valid_in  (v6),
    .ctrl_in   (ctrl6),
    .side_in   (dmag6),
    .radicand  (sq6),
    .valid_out (vr),
    .ctrl_out  (ctrlr),
    .side_out  (dmagr),
    .root      (root)
  );

  // output register: pick magnitude and apply direction
  logic [S-1:0] mag;
  logic [S:0]   mag_x;
  assign mag   = ctrlr.use_root ? root : dmagr;
  assign mag_x = {1'b0, mag};

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vr;
    end
  end

  always_ff @(posedge clk) begin
    target_speed <= ctrlr.neg ? -mag_x : mag_x;
    region       <= ctrlr.region;
  end

`ifndef SYNTH
  localparam int Latency = 3 * SPEED_WIDTH + 7;

  // every result traces back to an earlier accepted command word
  a_done_has_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, Latency))
    else $error("result word without a matching command word");

  // bad settings always give zero speed
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (done && region == tvp_pkg::REGION_INVALID) |-> (target_speed == '0))
    else $error("invalid settings gave a nonzero speed");

  // hold mode never flips the sign
  a_hold_positive: assert property (@(posedge clk) disable iff (rst)
    (done && region == tvp_pkg::REGION_HOLD) |-> !target_speed[SPEED_WIDTH])
    else $error("hold mode gave a negative speed");
`endif

endmodule
